>>> hw/rtl/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types, sizes and codes of the multi-channel 1-D convolution core.
// ----------------------------------------------------------------------------
package mcc_pkg;

  // storage sizes
  localparam int MAX_CHANNELS = 64;
  localparam int MAX_TAPS     = 7;
  localparam int MAX_STEPS    = 1024;

  // item field widths
  localparam int OP_W  = 2;
  localparam int CH_W  = 6;
  localparam int TAP_W = 3;
  localparam int TS_W  = 10;
  localparam int VAL_W = 16;

  // configuration register widths
  localparam int CFG_CH_W  = 7;
  localparam int CFG_K_W   = 3;
  localparam int CFG_LEN_W = 11;

  // memory geometry
  localparam int W_DEPTH = MAX_CHANNELS * MAX_CHANNELS * MAX_TAPS;
  localparam int W_AW    = $clog2(W_DEPTH);
  localparam int X_DEPTH = MAX_CHANNELS * MAX_STEPS;
  localparam int X_AW    = $clog2(X_DEPTH);
  localparam int B_AW    = $clog2(MAX_CHANNELS);

  // datapath widths
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 40;
  localparam int FRAC_W = 12;
  localparam int IDX_W  = CFG_LEN_W + 1;

  // configuration port
  localparam int REG_COUNT = 4;
  localparam int PADDR_W   = $clog2(REG_COUNT) + 2;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = $clog2(REG_COUNT);

  localparam logic [REG_IDX_W-1:0] REG_IN_CHANNELS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OUT_CHANNELS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_LEN   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SEQ_LEN      = 2'd3;

  // reset values of the registers
  localparam logic [CFG_CH_W-1:0]  RST_IN_CHANNELS  = 7'd1;
  localparam logic [CFG_CH_W-1:0]  RST_OUT_CHANNELS = 7'd1;
  localparam logic [CFG_K_W-1:0]   RST_KERNEL_LEN   = 3'd3;
  localparam logic [CFG_LEN_W-1:0] RST_SEQ_LEN      = 11'd1024;

  // item operations
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_BIAS   = 2'd1,
    OP_LOAD_SAMPLE = 2'd2,
    OP_COMPUTE     = 2'd3
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_BIAS,
    S_MAC,
    S_DRAIN1,
    S_DRAIN2,
    S_ROUND,
    S_DONE
  } state_e;

endpackage

>>> hw/rtl/mcc_req_if.sv
// ----------------------------------------------------------------------------
// mcc_req_if
// Input item channel: load and compute requests with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcc_req_if;
  import mcc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [CH_W-1:0]         out_ch;
  logic [CH_W-1:0]         in_ch;
  logic [TAP_W-1:0]        tap;
  logic [TS_W-1:0]         time_step;
  logic signed [VAL_W-1:0] value;

  modport source (
    output valid, operation, out_ch, in_ch, tap, time_step, value,
    input  ready
  );

  modport sink (
    input  valid, operation, out_ch, in_ch, tap, time_step, value,
    output ready
  );
endinterface

>>> hw/rtl/mcc_rsp_if.sv
// ----------------------------------------------------------------------------
// mcc_rsp_if
// Result item channel: convolution result and flags with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcc_rsp_if;
  import mcc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] y_value;
  logic                    is_output;
  logic                    saturated;

  modport source (
    output valid, y_value, is_output, saturated,
    input  ready
  );

  modport sink (
    input  valid, y_value, is_output, saturated,
    output ready
  );
endinterface

>>> hw/rtl/multichannel_conv1d_same_core.sv
// ----------------------------------------------------------------------------
// multichannel_conv1d_same_core
// Multi-channel 1-D cross-correlation, zero padded, same length, Q3.12.
// Loads and out-of-range computes go from acceptance to the output register;
// computes pass the bias, multiply-accumulate, drain and round states first.
// No new item is taken until the last result is in the output register; one
// shared 16x16 multiplier and the 40-bit accumulator take one tap per cycle.
// A full, stalled output holds the result in the done state.
// rst_ni resets the sequencer and config registers; memories are not cleared.
// ----------------------------------------------------------------------------
module multichannel_conv1d_same_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mcc_req_if.sink                       req_i,
  mcc_rsp_if.source                     rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcc_pkg::PADDR_W-1:0]   paddr,
  input  logic [mcc_pkg::PDATA_W-1:0]   pwdata,
  output logic [mcc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import mcc_pkg::*;

  // configuration registers
  logic [CFG_CH_W-1:0]  in_channels_q, out_channels_q;
  logic [CFG_K_W-1:0]   kernel_len_q;
  logic [CFG_LEN_W-1:0] seq_len_q;

  // sequencer
  state_e state_q, state_d;

  // item registers
  logic [CH_W-1:0] oc_q;
  logic [TS_W-1:0] ts_q;
  logic [CH_W-1:0] ci_q, ci_d;
  logic [CFG_K_W-1:0] k_q, k_d;

  // memories
  logic signed [VAL_W-1:0] w_mem [W_DEPTH];
  logic signed [VAL_W-1:0] x_mem [X_DEPTH];
  logic signed [VAL_W-1:0] b_mem [MAX_CHANNELS];
  logic signed [VAL_W-1:0] w_rd_q, x_rd_q, b_rd_q;

  // pipeline
  logic                     s1_vld_q, s1_vld_d;
  logic                     s2_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  // pending result and output register
  logic signed [VAL_W-1:0] res_y_q, res_y_d;
  logic                    res_out_q, res_out_d;
  logic                    res_sat_q, res_sat_d;
  logic                    out_vld_q;
  logic signed [VAL_W-1:0] out_y_q;
  logic                    out_is_q, out_sat_q;

  // control
  logic       req_fire, cfg_wr, out_load, mac_last, tap_ok;
  logic       compute_ok;
  op_e        req_op;
  logic [REG_IDX_W-1:0] reg_idx;

  // effective register values
  logic [CFG_CH_W-1:0]  nci, nco;
  logic [CFG_K_W-1:0]   nk, pad;
  logic [CFG_LEN_W-1:0] nt;

  // addresses
  logic [W_AW-1:0]  w_wr_addr, w_rd_addr;
  logic [X_AW-1:0]  x_wr_addr, x_rd_addr;
  logic signed [IDX_W-1:0] idx;

  // rounding
  logic signed [ACC_W-1:0]        acc_rnd;
  logic signed [ACC_W-FRAC_W-1:0] acc_sh;

  // ---------------------------------------------------------------- config
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_channels_q  <= RST_IN_CHANNELS;
      out_channels_q <= RST_OUT_CHANNELS;
      kernel_len_q   <= RST_KERNEL_LEN;
      seq_len_q      <= RST_SEQ_LEN;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_IN_CHANNELS:  in_channels_q  <= pwdata[CFG_CH_W-1:0];
        REG_OUT_CHANNELS: out_channels_q <= pwdata[CFG_CH_W-1:0];
        REG_KERNEL_LEN:   kernel_len_q   <= pwdata[CFG_K_W-1:0];
        REG_SEQ_LEN:      seq_len_q      <= pwdata[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_IN_CHANNELS:  prdata = PDATA_W'(in_channels_q);
      REG_OUT_CHANNELS: prdata = PDATA_W'(out_channels_q);
      REG_KERNEL_LEN:   prdata = PDATA_W'(kernel_len_q);
      REG_SEQ_LEN:      prdata = PDATA_W'(seq_len_q);
      default:          prdata = '0;
    endcase
  end

  // clamp registers into their legal ranges, zero acts as one
  always_comb begin
    if (in_channels_q == '0) nci = CFG_CH_W'(1);
    else if (in_channels_q > CFG_CH_W'(MAX_CHANNELS)) nci = CFG_CH_W'(MAX_CHANNELS);
    else nci = in_channels_q;

    if (out_channels_q == '0) nco = CFG_CH_W'(1);
    else if (out_channels_q > CFG_CH_W'(MAX_CHANNELS)) nco = CFG_CH_W'(MAX_CHANNELS);
    else nco = out_channels_q;

    if (kernel_len_q == '0) nk = CFG_K_W'(1);
    else if (kernel_len_q > CFG_K_W'(MAX_TAPS)) nk = CFG_K_W'(MAX_TAPS);
    else nk = kernel_len_q;

    if (seq_len_q == '0) nt = CFG_LEN_W'(1);
    else if (seq_len_q > CFG_LEN_W'(MAX_STEPS)) nt = CFG_LEN_W'(MAX_STEPS);
    else nt = seq_len_q;

    pad = (nk - CFG_K_W'(1)) >> 1;
  end

  // ---------------------------------------------------------------- input side
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign req_op      = op_e'(req_i.operation);

  assign compute_ok = (CFG_CH_W'(req_i.out_ch) < nco) &&
                      (CFG_LEN_W'(req_i.time_step) < nt);

  // load addresses
  assign w_wr_addr = W_AW'(req_i.out_ch) * W_AW'(MAX_CHANNELS * MAX_TAPS) +
                     W_AW'(req_i.in_ch) * W_AW'(MAX_TAPS) + W_AW'(req_i.tap);
  assign x_wr_addr = X_AW'(req_i.in_ch) * X_AW'(MAX_STEPS) + X_AW'(req_i.time_step);

  // ---------------------------------------------------------------- sequencer
  assign mac_last = (k_q == nk - CFG_K_W'(1)) &&
                    ({1'b0, ci_q} == nci - CFG_CH_W'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          if (req_op == OP_COMPUTE && compute_ok) state_d = S_BIAS;
          else state_d = S_DONE;
        end
      end
      S_BIAS:   state_d = S_MAC;
      S_MAC:    if (mac_last) state_d = S_DRAIN1;
      S_DRAIN1: state_d = S_DRAIN2;
      S_DRAIN2: state_d = S_ROUND;
      S_ROUND:  state_d = S_DONE;
      S_DONE:   if (!out_vld_q || rsp_o.ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // ---------------------------------------------------------------- control outputs
  // tap position and its bounds check
  assign idx    = IDX_W'($signed({1'b0, ts_q})) + IDX_W'($signed({1'b0, k_q})) -
                  IDX_W'($signed({1'b0, pad}));
  assign tap_ok = !idx[IDX_W-1] && (idx[CFG_LEN_W-1:0] < nt);

  assign w_rd_addr = W_AW'(oc_q) * W_AW'(MAX_CHANNELS * MAX_TAPS) +
                     W_AW'(ci_q) * W_AW'(MAX_TAPS) + W_AW'(k_q);
  assign x_rd_addr = X_AW'(ci_q) * X_AW'(MAX_STEPS) + X_AW'(idx[TS_W-1:0]);

  // rounding half up and saturation
  assign acc_rnd = acc_q + ACC_W'(1 << (FRAC_W - 1));
  assign acc_sh  = acc_rnd[ACC_W-1:FRAC_W];

  assign out_load = (state_q == S_DONE) && (!out_vld_q || rsp_o.ready);

  always_comb begin
    ci_d      = ci_q;
    k_d       = k_q;
    s1_vld_d  = 1'b0;
    acc_d     = acc_q;
    res_y_d   = res_y_q;
    res_out_d = res_out_q;
    res_sat_d = res_sat_q;
    case (state_q)
      S_IDLE: begin
        // loads and out-of-range computes answer with zero
        if (req_fire) begin
          res_y_d   = '0;
          res_out_d = (req_op == OP_COMPUTE);
          res_sat_d = 1'b0;
        end
      end
      S_BIAS: begin
        ci_d  = '0;
        k_d   = '0;
        acc_d = ACC_W'(b_rd_q) <<< FRAC_W;
      end
      S_MAC: begin
        s1_vld_d = tap_ok;
        if (k_q == nk - CFG_K_W'(1)) begin
          k_d  = '0;
          ci_d = ci_q + CH_W'(1);
        end else begin
          k_d = k_q + CFG_K_W'(1);
        end
      end
      S_ROUND: begin
        if (acc_sh > (ACC_W-FRAC_W)'(32767)) begin
          res_y_d   = VAL_W'(32767);
          res_sat_d = 1'b1;
        end else if (acc_sh < -(ACC_W-FRAC_W)'(32768)) begin
          res_y_d   = VAL_W'(-32768);
          res_sat_d = 1'b1;
        end else begin
          res_y_d   = acc_sh[VAL_W-1:0];
          res_sat_d = 1'b0;
        end
      end
      default: ;
    endcase
    // accumulate products leaving the multiplier
    if (state_q != S_BIAS && s2_vld_q) acc_d = acc_q + ACC_W'(prod_q);
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk_i) begin
    if (req_fire && req_op == OP_LOAD_WEIGHT && req_i.tap < TAP_W'(MAX_TAPS)) begin
      w_mem[w_wr_addr] <= req_i.value;
    end
    w_rd_q <= w_mem[w_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_fire && req_op == OP_LOAD_SAMPLE) begin
      x_mem[x_wr_addr] <= req_i.value;
    end
    x_rd_q <= x_mem[x_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_fire && req_op == OP_LOAD_BIAS) begin
      b_mem[req_i.out_ch] <= req_i.value;
    end
    b_rd_q <= b_mem[req_i.out_ch];
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      oc_q <= req_i.out_ch;
      ts_q <= req_i.time_step;
    end
    ci_q      <= ci_d;
    k_q       <= k_d;
    prod_q    <= w_rd_q * x_rd_q;
    acc_q     <= acc_d;
    res_y_q   <= res_y_d;
    res_out_q <= res_out_d;
    res_sat_q <= res_sat_d;
  end

  // multiplier pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s1_vld_q;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_y_q   <= res_y_q;
      out_is_q  <= res_out_q;
      out_sat_q <= res_sat_q;
    end
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.y_value   = out_y_q;
  assign rsp_o.is_output = out_is_q;
  assign rsp_o.saturated = out_sat_q;

  // ---------------------------------------------------------------- assertions
  // load items always answer with zero result and no flags
  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.is_output |-> rsp_o.y_value == '0 && !rsp_o.saturated)
    else $error("load item result not zero");

  // a saturated result sits at one of the rails
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.saturated |->
      rsp_o.y_value == 16'sh7fff || rsp_o.y_value == 16'sh8000)
    else $error("saturated result off the rails");

  // the block is busy in the cycle after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("item taken while previous one in work");

  // the channel and tap counters stay inside the configured ranges while summing
  a_ci_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MAC |-> {1'b0, ci_q} < nci && k_q < nk)
    else $error("tap counter out of range");

endmodule

>>> bench/conv1d_checker.sv
// ----------------------------------------------------------------------------
// conv1d_checker
// Watches the item channels and the register port of the convolution core,
// keeps its own copy of the three stores and the registers, works out the
// result of every accepted item and compares it with what the core returns.
// Register reads are checked against the register copy as well.
// ----------------------------------------------------------------------------
module conv1d_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mcc_req_if                            req_i,
  mcc_rsp_if                            rsp_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcc_pkg::PADDR_W-1:0]   paddr,
  input  logic [mcc_pkg::PDATA_W-1:0]   pwdata,
  input  logic [mcc_pkg::PDATA_W-1:0]   prdata,
  input  logic                          pready,
  output int                            fail_count_o,
  output int                            pending_o
);
  import mcc_pkg::*;

  typedef struct packed {
    logic signed [VAL_W-1:0] y_value;
    logic                    is_output;
    logic                    saturated;
  } conv_result_t;

  localparam logic signed [ACC_W-1:0] Y_MAX = 40'sd32767;
  localparam logic signed [ACC_W-1:0] Y_MIN = -40'sd32768;

  // own copy of the stores, written only by load items
  logic signed [VAL_W-1:0] weight_mem [W_DEPTH];
  logic signed [VAL_W-1:0] bias_mem   [MAX_CHANNELS];
  logic signed [VAL_W-1:0] sample_mem [X_DEPTH];

  // own copy of the registers
  logic [CFG_CH_W-1:0]  in_channels_q;
  logic [CFG_CH_W-1:0]  out_channels_q;
  logic [CFG_K_W-1:0]   kernel_len_q;
  logic [CFG_LEN_W-1:0] seq_len_q;

  conv_result_t conv_results_q [$];
  conv_result_t oldest;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic record_mismatch(string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("mismatch: %0s", msg);
  endtask

  function automatic int clamp_count(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PDATA_W-1:0] reg_readback(logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_IN_CHANNELS:  return PDATA_W'(in_channels_q);
      REG_OUT_CHANNELS: return PDATA_W'(out_channels_q);
      REG_KERNEL_LEN:   return PDATA_W'(kernel_len_q);
      REG_SEQ_LEN:      return PDATA_W'(seq_len_q);
      default:          return '0;
    endcase
  endfunction

  // store update for loads, correlation with zero padding for compute items
  function automatic conv_result_t predict_item(op_e op, int oc, int ic, int tap, int ts,
                                                logic signed [VAL_W-1:0] val);
    conv_result_t             res;
    logic signed [ACC_W-1:0]  acc;
    logic signed [PROD_W-1:0] prod;
    int                       nci, nco, nk, nt, pad, idx;
    res = '0;
    case (op)
      OP_LOAD_WEIGHT: begin
        // taps beyond the store are dropped
        if (tap < MAX_TAPS) weight_mem[(oc * MAX_CHANNELS + ic) * MAX_TAPS + tap] = val;
      end
      OP_LOAD_BIAS: begin
        bias_mem[oc] = val;
      end
      OP_LOAD_SAMPLE: begin
        sample_mem[ic * MAX_STEPS + ts] = val;
      end
      default: begin
        res.is_output = 1'b1;
        nci = clamp_count(in_channels_q, MAX_CHANNELS);
        nco = clamp_count(out_channels_q, MAX_CHANNELS);
        nk  = clamp_count(kernel_len_q, MAX_TAPS);
        nt  = clamp_count(seq_len_q, MAX_STEPS);
        pad = (nk - 1) / 2;
        // out of range requests give a zero result
        if (oc < nco && ts < nt) begin
          acc = bias_mem[oc];
          acc = acc <<< FRAC_W;
          for (int ci = 0; ci < nci; ci++) begin
            for (int k = 0; k < nk; k++) begin
              idx = ts - pad + k;
              if (idx >= 0 && idx < nt) begin
                prod = sample_mem[ci * MAX_STEPS + idx] *
                       weight_mem[(oc * MAX_CHANNELS + ci) * MAX_TAPS + k];
                acc  = acc + prod;
              end
            end
          end
          // round half up, then clip to 16 bits
          acc = acc + (ACC_W'(1) << (FRAC_W - 1));
          acc = acc >>> FRAC_W;
          if (acc > Y_MAX) begin
            acc           = Y_MAX;
            res.saturated = 1'b1;
          end else if (acc < Y_MIN) begin
            acc           = Y_MIN;
            res.saturated = 1'b1;
          end
          res.y_value = acc[VAL_W-1:0];
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_channels_q  = RST_IN_CHANNELS;
      out_channels_q = RST_OUT_CHANNELS;
      kernel_len_q   = RST_KERNEL_LEN;
      seq_len_q      = RST_SEQ_LEN;
      conv_results_q.delete();
      pending_o      = 0;
    end else begin
      // register port: writes update the copy, reads are checked
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[PADDR_W-1:2])
            REG_IN_CHANNELS:  in_channels_q  = pwdata[CFG_CH_W-1:0];
            REG_OUT_CHANNELS: out_channels_q = pwdata[CFG_CH_W-1:0];
            REG_KERNEL_LEN:   kernel_len_q   = pwdata[CFG_K_W-1:0];
            REG_SEQ_LEN:      seq_len_q      = pwdata[CFG_LEN_W-1:0];
            default: ;
          endcase
        end else if (prdata !== reg_readback(paddr[PADDR_W-1:2])) begin
          record_mismatch($sformatf("register %0d read: expected %0h, got %0h",
                                    paddr[PADDR_W-1:2], reg_readback(paddr[PADDR_W-1:2]),
                                    prdata));
        end
      end
      // accepted input item, queued behind the ones still outstanding
      if (req_i.valid && req_i.ready) begin
        conv_results_q.insert(conv_results_q.size(),
                              predict_item(op_e'(req_i.operation), req_i.out_ch,
                                           req_i.in_ch, req_i.tap, req_i.time_step,
                                           req_i.value));
      end
      // accepted result item against the oldest outstanding one
      if (rsp_i.valid && rsp_i.ready) begin
        if (conv_results_q.size() == 0) begin
          record_mismatch($sformatf("result item with none outstanding: y_value %0d",
                                    rsp_i.y_value));
        end else begin
          oldest = conv_results_q.pop_front();
          if (rsp_i.y_value !== oldest.y_value)
            record_mismatch($sformatf("y_value: expected %0d, got %0d",
                                      oldest.y_value, rsp_i.y_value));
          if (rsp_i.is_output !== oldest.is_output)
            record_mismatch($sformatf("is_output: expected %0b, got %0b",
                                      oldest.is_output, rsp_i.is_output));
          if (rsp_i.saturated !== oldest.saturated)
            record_mismatch($sformatf("saturated: expected %0b, got %0b",
                                      oldest.saturated, rsp_i.saturated));
        end
      end
      pending_o = conv_results_q.size();
    end
  end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the multi-channel 1-D convolution core. Runs a
// short directed set at the reset settings, then random load and compute
// items over several register settings, with random gaps on both channels.
// Every compute item only reads store entries that were loaded before it.
// ----------------------------------------------------------------------------
module testbench;
  import mcc_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;

  mcc_req_if req_ch ();
  mcc_rsp_if rsp_ch ();

  multichannel_conv1d_same_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  conv1d_checker result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // entries loaded so far, so that compute items never read an empty entry
  bit weight_set [W_DEPTH];
  bit bias_set   [MAX_CHANNELS];
  bit sample_set [X_DEPTH];

  // settings in force, as the core uses them
  int eff_in, eff_out, eff_k, eff_len;
  int items_sent;
  int send_idle_pct;
  int recv_idle_pct;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // overall limit
  initial begin
    #(64'd20 * 64'd400000);
    $display("CHECKS FAILED");
    $finish;
  end

  // result side stalls
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic int clamp_count(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // mix of full range, small and extreme Q3.12 values
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2: return VAL_W'($urandom());
      3, 4, 5: return VAL_W'($urandom_range(8191)) - VAL_W'(4096);
      6, 7:    return VAL_W'($urandom_range(1023)) - VAL_W'(512);
      8:       return 16'sh7fff;
      default: return 16'sh8000;
    endcase
  endfunction

  // one input item, with random gaps before it
  task automatic send_item(op_e op, int oc, int ic, int tap, int ts,
                           logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.out_ch    <= CH_W'(oc);
    req_ch.in_ch     <= CH_W'(ic);
    req_ch.tap       <= TAP_W'(tap);
    req_ch.time_step <= TS_W'(ts);
    req_ch.value     <= val;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    case (op)
      OP_LOAD_WEIGHT: if (tap < MAX_TAPS) weight_set[(oc * MAX_CHANNELS + ic) * MAX_TAPS + tap] = 1'b1;
      OP_LOAD_BIAS:   bias_set[oc] = 1'b1;
      OP_LOAD_SAMPLE: sample_set[ic * MAX_STEPS + ts] = 1'b1;
      default: ;
    endcase
    items_sent++;
    // idle pattern over the run: sender light, then receiver light, then none
    if (items_sent < 450) begin
      send_idle_pct = 10;
      recv_idle_pct = 61;
    end else if (items_sent < 900) begin
      send_idle_pct = 61;
      recv_idle_pct = 10;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // register write: setup then access, then back to idle
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int unsigned data, int width);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (PDATA_W'($urandom()) << width) | PDATA_W'(data);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic read_reg(logic [REG_IDX_W-1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // new settings once every result item is back
  task automatic configure(int in_v, int out_v, int k_v, int len_v);
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    write_reg(REG_IN_CHANNELS, in_v, CFG_CH_W);
    write_reg(REG_OUT_CHANNELS, out_v, CFG_CH_W);
    write_reg(REG_KERNEL_LEN, k_v, CFG_K_W);
    write_reg(REG_SEQ_LEN, len_v, CFG_LEN_W);
    for (int i = 0; i < REG_COUNT; i++) read_reg(REG_IDX_W'(i));
    eff_in  = clamp_count(in_v % (1 << CFG_CH_W), MAX_CHANNELS);
    eff_out = clamp_count(out_v % (1 << CFG_CH_W), MAX_CHANNELS);
    eff_k   = clamp_count(k_v % (1 << CFG_K_W), MAX_TAPS);
    eff_len = clamp_count(len_v % (1 << CFG_LEN_W), MAX_STEPS);
  endtask

  // loads for one output point, some rewrites, then the compute item
  task automatic compute_sequence();
    int oc, t, pad, idx, ci, k;
    oc = ($urandom_range(4) == 0) ? eff_out - 1 : $urandom_range(eff_out - 1);
    case ($urandom_range(3))
      0:       t = 0;
      1:       t = eff_len - 1;
      default: t = $urandom_range(eff_len - 1);
    endcase
    pad = (eff_k - 1) / 2;
    repeat ($urandom_range(2)) begin
      ci = $urandom_range(eff_in - 1);
      k  = $urandom_range(eff_k - 1);
      send_item(OP_LOAD_WEIGHT, oc, ci, k, $urandom_range(1023), pick_value());
      idx = t - pad + k;
      if (idx >= 0 && idx < eff_len)
        send_item(OP_LOAD_SAMPLE, $urandom_range(63), ci, $urandom_range(7), idx, pick_value());
    end
    if (!bias_set[oc] || $urandom_range(3) == 0)
      send_item(OP_LOAD_BIAS, oc, $urandom_range(63), $urandom_range(7), $urandom_range(1023),
                pick_value());
    for (ci = 0; ci < eff_in; ci++) begin
      for (k = 0; k < eff_k; k++) begin
        idx = t - pad + k;
        if (idx >= 0 && idx < eff_len) begin
          if (!weight_set[(oc * MAX_CHANNELS + ci) * MAX_TAPS + k])
            send_item(OP_LOAD_WEIGHT, oc, ci, k, $urandom_range(1023), pick_value());
          if (!sample_set[ci * MAX_STEPS + idx])
            send_item(OP_LOAD_SAMPLE, $urandom_range(63), ci, $urandom_range(7), idx,
                      pick_value());
        end
      end
    end
    send_item(OP_COMPUTE, oc, $urandom_range(63), $urandom_range(7), t, pick_value());
  endtask

  // stray loads with any field values, or compute items out of range
  task automatic noise_item();
    int oc, ts;
    if ($urandom_range(2) == 0 && (eff_out < MAX_CHANNELS || eff_len < MAX_STEPS)) begin
      oc = $urandom_range(63);
      ts = $urandom_range(1023);
      if (eff_out < MAX_CHANNELS && ($urandom_range(1) == 0 || eff_len >= MAX_STEPS))
        oc = $urandom_range(63, eff_out);
      else
        ts = $urandom_range(1023, eff_len);
      send_item(OP_COMPUTE, oc, $urandom_range(63), $urandom_range(7), ts, pick_value());
    end else begin
      send_item(op_e'($urandom_range(2)), $urandom_range(63), $urandom_range(63),
                $urandom_range(7), $urandom_range(1023), pick_value());
    end
  endtask

  task automatic run_phase(int in_v, int out_v, int k_v, int len_v, int budget);
    int stop;
    configure(in_v, out_v, k_v, len_v);
    stop = items_sent + budget;
    while (items_sent < stop) begin
      if ($urandom_range(9) < 8) compute_sequence();
      else noise_item();
    end
  endtask

  // main stimulus
  initial begin
    int waited;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_LOAD_WEIGHT;
    req_ch.out_ch    = '0;
    req_ch.in_ch     = '0;
    req_ch.tap       = '0;
    req_ch.time_step = '0;
    req_ch.value     = '0;
    items_sent       = 0;
    send_idle_pct    = 10;
    recv_idle_pct    = 61;
    eff_in           = clamp_count(RST_IN_CHANNELS, MAX_CHANNELS);
    eff_out          = clamp_count(RST_OUT_CHANNELS, MAX_CHANNELS);
    eff_k            = clamp_count(RST_KERNEL_LEN, MAX_TAPS);
    eff_len          = clamp_count(RST_SEQ_LEN, MAX_STEPS);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values read back
    for (int i = 0; i < REG_COUNT; i++) read_reg(REG_IDX_W'(i));

    // directed part at the reset settings: full scale values, both edges
    send_item(OP_LOAD_BIAS, 0, 0, 0, 0, 16'sh7fff);
    send_item(OP_LOAD_WEIGHT, 0, 0, 0, 0, 16'sh7fff);
    send_item(OP_LOAD_WEIGHT, 0, 0, 1, 0, 16'sh7fff);
    send_item(OP_LOAD_WEIGHT, 0, 0, 2, 0, 16'sh7fff);
    // tap beyond the store is dropped
    send_item(OP_LOAD_WEIGHT, 0, 0, 7, 0, 16'sh1234);
    send_item(OP_LOAD_SAMPLE, 0, 0, 0, 0, 16'sh7fff);
    send_item(OP_LOAD_SAMPLE, 0, 0, 0, 1, 16'sh7fff);
    send_item(OP_LOAD_SAMPLE, 0, 0, 0, 2, 16'sh0001);
    send_item(OP_LOAD_SAMPLE, 0, 0, 0, 1022, 16'sh8000);
    send_item(OP_LOAD_SAMPLE, 0, 0, 0, 1023, 16'sh8000);
    // left padding, interior, right padding: clipping both ways
    send_item(OP_COMPUTE, 0, 0, 0, 0, 16'sh0000);
    send_item(OP_COMPUTE, 0, 0, 0, 1, 16'sh0000);
    send_item(OP_COMPUTE, 0, 0, 0, 1023, 16'sh0000);
    // output channel not in use
    send_item(OP_COMPUTE, 1, 0, 0, 5, 16'sh0000);
    // top corners of the stores
    send_item(OP_LOAD_BIAS, 63, 63, 7, 1023, 16'shffff);
    send_item(OP_LOAD_WEIGHT, 63, 63, 6, 1023, 16'sh5a5a);
    send_item(OP_LOAD_SAMPLE, 63, 63, 7, 1023, 16'sha5a5);
    // rounding half up on a single tap
    send_item(OP_LOAD_BIAS, 0, 0, 0, 0, 16'sh0000);
    send_item(OP_LOAD_WEIGHT, 0, 0, 0, 0, 16'sh0000);
    send_item(OP_LOAD_WEIGHT, 0, 0, 1, 0, 16'sh0001);
    send_item(OP_LOAD_WEIGHT, 0, 0, 2, 0, 16'sh0000);
    send_item(OP_LOAD_SAMPLE, 0, 0, 0, 1, 16'sh0800);
    send_item(OP_COMPUTE, 0, 0, 0, 1, 16'sh0000);
    send_item(OP_LOAD_SAMPLE, 0, 0, 0, 1, -16'sh0800);
    send_item(OP_COMPUTE, 0, 0, 0, 1, 16'sh0000);

    // random part over several settings, extremes and clamped values among them
    run_phase(2, 4, 5, 16, 220);
    run_phase(1, 64, 7, 1024, 200);
    run_phase(127, 1, 1, 3, 200);
    run_phase(3, 2, 4, 9, 180);
    run_phase(0, 0, 0, 0, 100);
    run_phase(64, 2, 1, 2047, 150);
    run_phase(5, 8, 6, 40, 200);
    run_phase(1, 1, 3, 1024, 80);

    // drain
    req_ch.valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 50000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (500) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/mcc_pkg.sv
hw/rtl/mcc_req_if.sv
hw/rtl/mcc_rsp_if.sv
hw/rtl/multichannel_conv1d_same_core.sv
bench/conv1d_checker.sv
bench/testbench.sv
